>>> rtl/fcg_pkg.sv
// shared types, codes and constants of the floppy card glue logic
package fcg_pkg;

  localparam int unsigned ADDR_WIDTH_DEF = 21;
  localparam int unsigned SEL_WIDTH      = 21;
  localparam int unsigned TICK_WIDTH     = 16;
  localparam int unsigned CFG_IDX_WIDTH  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WIN_MASK    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WIN_BASE    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MOTOR_TICKS = 2'd2;

  localparam logic [SEL_WIDTH-1:0]  WIN_MASK_RST    = 21'h7e000;
  localparam logic [SEL_WIDTH-1:0]  WIN_BASE_RST    = 21'h74000;
  localparam logic [TICK_WIDTH-1:0] MOTOR_TICKS_RST = 16'd4230;

  // operation codes
  typedef enum logic [2:0] {
    OP_CRU_READ  = 3'd0,
    OP_CRU_WRITE = 3'd1,
    OP_MEM_READ  = 3'd2,
    OP_MEM_WRITE = 3'd3,
    OP_IRQ_LINE  = 3'd4,
    OP_DRQ_LINE  = 3'd5,
    OP_TICK      = 3'd6
  } fcg_op_e;

  // controller access kinds
  localparam logic [1:0] CTL_NONE  = 2'd0;
  localparam logic [1:0] CTL_READ  = 2'd1;
  localparam logic [1:0] CTL_WRITE = 2'd2;

  // cru bit numbers within the card's group
  localparam logic [2:0] CRU_CARD_SEL = 3'd0;
  localparam logic [2:0] CRU_MOTOR    = 3'd1;
  localparam logic [2:0] CRU_HOLD     = 3'd2;
  localparam logic [2:0] CRU_HEAD     = 3'd3;
  localparam logic [2:0] CRU_DRIVE1   = 3'd4;
  localparam logic [2:0] CRU_DRIVE2   = 3'd5;
  localparam logic [2:0] CRU_DRIVE3   = 3'd6;
  localparam logic [2:0] CRU_SIDE     = 3'd7;

  localparam logic [7:0]  CRU_BASE_HI  = 8'h11;
  localparam logic [12:0] REG_DEC_MASK = 13'h1ff9;
  localparam logic [12:0] REG_RD_MATCH = 13'h1ff0;
  localparam logic [12:0] REG_WR_MATCH = 13'h1ff8;
  localparam logic [7:0]  CRU_RD_ONE   = 8'h40;
  localparam logic [7:0]  CRU_RD_MOFF  = 8'h10;

  typedef struct packed {
    logic [SEL_WIDTH-1:0]  win_mask;
    logic [SEL_WIDTH-1:0]  win_base;
    logic [TICK_WIDTH-1:0] motor_ticks;
  } fcg_cfg_t;

  typedef struct packed {
    logic                  card_selected;
    logic                  motor_strobe;
    logic                  motor_run;
    logic                  hold_enable;
    logic [2:0]            drive_mask;
    logic                  side;
    logic [1:0]            irq_drq_flags;
    logic [TICK_WIDTH-1:0] motor_countdown;
  } fcg_state_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_out;
    logic        rom_select;
    logic [12:0] rom_address;
    logic [1:0]  ctl_access;
    logic [1:0]  ctl_register;
    logic        halt_line;
    logic        intb_line;
    logic [2:0]  drive_bits;
    logic        side_select;
    logic [1:0]  drive_set;
    logic        motor_enable;
  } fcg_result_t;

endpackage

>>> rtl/fcg_in_if.sv
// input channel of the floppy card glue logic
interface fcg_in_if #(
  parameter int unsigned AddrWidth = fcg_pkg::ADDR_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           operation;
  logic [AddrWidth-1:0] address;
  logic [7:0]           data;
  logic [7:0]           controller_data;
  logic                 line_level;

  modport source (
    output valid, operation, address, data, controller_data, line_level,
    input  ready
  );
  modport sink (
    input  valid, operation, address, data, controller_data, line_level,
    output ready
  );
endinterface

>>> rtl/fcg_out_if.sv
// result channel of the floppy card glue logic
interface fcg_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  data_out;
  logic        rom_select;
  logic [12:0] rom_address;
  logic [1:0]  ctl_access;
  logic [1:0]  ctl_register;
  logic        halt_line;
  logic        intb_line;
  logic [2:0]  drive_bits;
  logic        side_select;
  logic [1:0]  drive_set;
  logic        motor_enable;

  modport source (
    output valid, data_valid, data_out, rom_select, rom_address, ctl_access,
           ctl_register, halt_line, intb_line, drive_bits, side_select,
           drive_set, motor_enable,
    input  ready
  );
  modport sink (
    input  valid, data_valid, data_out, rom_select, rom_address, ctl_access,
           ctl_register, halt_line, intb_line, drive_bits, side_select,
           drive_set, motor_enable,
    output ready
  );
endinterface

>>> rtl/floppy_card_glue_logic.sv
// top level of the floppy card glue logic
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    operation, address, data, controller_data, line_level
//   out_o     out  valid/ready    data_valid .. motor_enable, one result per transaction
//   cfg       in   cfg_we_i       cfg_index_i, cfg_data_i (write only)
//
// one transaction per clock sustained while out_o is not stalled; an accepted item passes
// the input register, then decode into the result register that also updates card state
// asynchronous active-low reset clears card state and valid flags, config to defaults
// a stalled result holds the result register and the input register, and input ready
// drops only when both are full
module floppy_card_glue_logic #(
  parameter int unsigned ADDRESS_WIDTH = fcg_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  fcg_in_if.sink                              in_i,
  fcg_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [fcg_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [fcg_pkg::SEL_WIDTH-1:0]       cfg_data_i
);
  import fcg_pkg::*;

  fcg_cfg_t                 cfg_q;
  fcg_state_t               state_q;
  fcg_state_t               state_d;
  fcg_result_t              res_q;
  fcg_result_t              res_d;
  logic                     s1_valid_q;
  logic [2:0]               s1_op_q;
  logic [ADDRESS_WIDTH-1:0] s1_addr_q;
  logic [7:0]               s1_data_q;
  logic [7:0]               s1_cdata_q;
  logic                     s1_level_q;
  logic                     out_valid_q;
  logic                     in_take;
  logic                     advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_mask    <= WIN_MASK_RST;
      cfg_q.win_base    <= WIN_BASE_RST;
      cfg_q.motor_ticks <= MOTOR_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIN_MASK:    cfg_q.win_mask    <= cfg_data_i;
        CFG_WIN_BASE:    cfg_q.win_base    <= cfg_data_i;
        CFG_MOTOR_TICKS: cfg_q.motor_ticks <= cfg_data_i[TICK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q    <= in_i.operation;
      s1_addr_q  <= in_i.address;
      s1_data_q  <= in_i.data;
      s1_cdata_q <= in_i.controller_data;
      s1_level_q <= in_i.line_level;
    end
  end

  fcg_core #(
    .AddrWidth (ADDRESS_WIDTH)
  ) u_core (
    .op_i      (s1_op_q),
    .address_i (s1_addr_q),
    .data_i    (s1_data_q),
    .cdata_i   (s1_cdata_q),
    .level_i   (s1_level_q),
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.data_valid   = res_q.data_valid;
  assign out_o.data_out     = res_q.data_out;
  assign out_o.rom_select   = res_q.rom_select;
  assign out_o.rom_address  = res_q.rom_address;
  assign out_o.ctl_access   = res_q.ctl_access;
  assign out_o.ctl_register = res_q.ctl_register;
  assign out_o.halt_line    = res_q.halt_line;
  assign out_o.intb_line    = res_q.intb_line;
  assign out_o.drive_bits   = res_q.drive_bits;
  assign out_o.side_select  = res_q.side_select;
  assign out_o.drive_set    = res_q.drive_set;
  assign out_o.motor_enable = res_q.motor_enable;

`ifndef NO_ASSERTIONS
  // the motor timer is running whenever the motor is on
  a_motor_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.motor_run |-> (state_q.motor_countdown != '0))
    else $error("motor on with expired timer");

  a_halt_needs_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!res_q.halt_line || res_q.motor_enable))
    else $error("halt without motor enable");

  a_drive_set_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.drive_set != 2'd0)) |-> res_q.drive_bits[res_q.drive_set - 2'd1])
    else $error("newly selected drive not in drive bits");

  a_ctl_excl_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.ctl_access != CTL_NONE)) |-> !res_q.rom_select)
    else $error("controller access and rom select together");
`endif

endmodule

>>> rtl/fcg_core.sv
// per-transaction decode: next card state and result from one registered item
module fcg_core #(
  parameter int unsigned AddrWidth = fcg_pkg::ADDR_WIDTH_DEF
) (
  input  logic [2:0]           op_i,
  input  logic [AddrWidth-1:0] address_i,
  input  logic [7:0]           data_i,
  input  logic [7:0]           cdata_i,
  input  logic                 level_i,
  input  fcg_pkg::fcg_cfg_t    cfg_i,
  input  fcg_pkg::fcg_state_t  state_i,
  output fcg_pkg::fcg_state_t  state_o,
  output fcg_pkg::fcg_result_t result_o
);
  import fcg_pkg::*;

  localparam int unsigned CmpWidth = (AddrWidth > SEL_WIDTH) ? AddrWidth : SEL_WIDTH;

  fcg_op_e             op;
  logic                cru_hit;
  logic                window;
  logic [2:0]          cru_bit;
  logic                set_bit;
  logic [12:0]         low_addr;
  logic [CmpWidth-1:0] addr_x;
  logic [CmpWidth-1:0] mask_x;
  logic [CmpWidth-1:0] value_x;
  fcg_state_t          nxt;
  fcg_result_t         res;

  assign op       = fcg_op_e'(op_i);
  assign cru_hit  = (address_i[15:8] == CRU_BASE_HI);
  assign cru_bit  = address_i[3:1];
  assign set_bit  = |data_i;
  assign low_addr = address_i[12:0];
  assign addr_x   = CmpWidth'(address_i);
  assign mask_x   = CmpWidth'(cfg_i.win_mask);
  assign value_x  = CmpWidth'(cfg_i.win_base);
  assign window   = state_i.card_selected && ((addr_x & mask_x) == value_x);

  always_comb begin
    nxt = state_i;
    res = '0;
    unique case (op)
      OP_CRU_READ: begin
        if (cru_hit) begin
          res.data_valid = 1'b1;
          if (address_i[2:0] == 3'd0) begin
            res.data_out = CRU_RD_ONE | {state_i.side, 7'd0};
            if (state_i.motor_run) begin
              res.data_out = res.data_out | {4'd0, state_i.drive_mask, 1'b0};
            end else begin
              res.data_out = res.data_out | CRU_RD_MOFF;
            end
          end
        end
      end
      OP_CRU_WRITE: begin
        if (cru_hit) begin
          unique case (cru_bit)
            CRU_CARD_SEL: nxt.card_selected = set_bit;
            CRU_MOTOR: begin
              // rising strobe edge restarts the motor timer
              if (set_bit && !state_i.motor_strobe) begin
                nxt.motor_run       = 1'b1;
                nxt.motor_countdown = (cfg_i.motor_ticks != '0) ? cfg_i.motor_ticks
                                                                 : TICK_WIDTH'(1);
              end
              nxt.motor_strobe = set_bit;
            end
            CRU_HOLD: nxt.hold_enable = set_bit;
            CRU_DRIVE1, CRU_DRIVE2, CRU_DRIVE3: begin
              if (set_bit) begin
                if (!state_i.drive_mask[cru_bit[1:0]]) begin
                  nxt.drive_mask[cru_bit[1:0]] = 1'b1;
                  res.drive_set = cru_bit[1:0] + 2'd1;
                end
              end else begin
                nxt.drive_mask[cru_bit[1:0]] = 1'b0;
              end
            end
            CRU_SIDE: nxt.side = set_bit;
            CRU_HEAD: ;
            default: ;
          endcase
        end
      end
      OP_MEM_READ: begin
        if (window) begin
          if ((low_addr & REG_DEC_MASK) == REG_RD_MATCH) begin
            res.ctl_access   = CTL_READ;
            res.ctl_register = address_i[2:1];
            res.data_out     = ~cdata_i;
            res.data_valid   = 1'b1;
          end else begin
            res.rom_select  = 1'b1;
            res.rom_address = low_addr;
          end
        end
      end
      OP_MEM_WRITE: begin
        if (window && ((low_addr & REG_DEC_MASK) == REG_WR_MATCH)) begin
          res.ctl_access   = CTL_WRITE;
          res.ctl_register = address_i[2:1];
          res.data_out     = ~data_i;
        end
      end
      OP_IRQ_LINE: nxt.irq_drq_flags[0] = level_i;
      OP_DRQ_LINE: nxt.irq_drq_flags[1] = level_i;
      OP_TICK: begin
        if (state_i.motor_countdown != '0) begin
          nxt.motor_countdown = state_i.motor_countdown - TICK_WIDTH'(1);
          if (state_i.motor_countdown == TICK_WIDTH'(1)) begin
            nxt.motor_run = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // levels after this transaction
    res.halt_line    = nxt.hold_enable && (nxt.irq_drq_flags == 2'd0) && nxt.motor_run;
    res.intb_line    = nxt.irq_drq_flags[0];
    res.drive_bits   = nxt.drive_mask;
    res.side_select  = nxt.side;
    res.motor_enable = nxt.motor_run;
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

>>> dv/tb_floppy_card_glue_logic.sv
// floppy card glue logic testbench: directed decode, motor, back-pressure cases, random traffic
module tb_floppy_card_glue_logic;
  import fcg_pkg::*;

  localparam int unsigned AW = ADDR_WIDTH_DEF;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS = 275;
  localparam int unsigned MAX_MISMATCH_LINES = 100;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [SEL_WIDTH-1:0]     cfg_data;

  fcg_in_if  in_ch ();
  fcg_out_if out_ch ();

  floppy_card_glue_logic dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // predicted card state and register copies
  fcg_cfg_t    cfg_shadow;
  fcg_state_t  card;
  fcg_result_t expected_results[$];

  int unsigned fail_count;
  int unsigned mismatch_lines;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned settings_used;
  int unsigned ctl_hits;
  int unsigned rom_hits;
  int unsigned motor_stops;
  bit          send_gaps_on;
  bit          recv_gaps_on;
  bit          long_hold_req;

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [AW-1:0] cru_at(input logic [2:0] cru_bit);
    return {{(AW-16){1'b0}}, CRU_BASE_HI, 4'd0, cru_bit, 1'b0};
  endfunction

  // address inside the reset-time card window
  function automatic logic [AW-1:0] win_at(input logic [12:0] offset);
    return {WIN_BASE_RST[AW-1:13], offset};
  endfunction

  // advances the predicted card by one transaction and returns the result it gives
  function automatic fcg_result_t card_step(input logic [2:0] op, input logic [AW-1:0] addr,
                                            input logic [7:0] wdata, input logic [7:0] cdata,
                                            input logic level);
    fcg_result_t r;
    logic        cru_hit;
    logic        in_window;
    logic        bit_set;
    logic [2:0]  cru_bit;
    logic [2:0]  drive_bit;
    r = '0;
    cru_hit = addr[15:8] == CRU_BASE_HI;
    in_window = card.card_selected &&
                ((addr & cfg_shadow.win_mask) == cfg_shadow.win_base);
    cru_bit = addr[3:1];
    bit_set = wdata != 8'd0;
    case (op)
      OP_CRU_READ: begin
        if (cru_hit) begin
          r.data_valid = 1'b1;
          // only the first bit group answers with status
          if (addr[2:0] == 3'd0) begin
            r.data_out = CRU_RD_ONE | {card.side, 7'd0} |
                         (card.motor_run ? {4'd0, card.drive_mask, 1'b0} : CRU_RD_MOFF);
          end
        end
      end
      OP_CRU_WRITE: begin
        if (cru_hit) begin
          case (cru_bit)
            CRU_CARD_SEL: card.card_selected = bit_set;
            CRU_MOTOR: begin
              if (bit_set && !card.motor_strobe) begin
                card.motor_run = 1'b1;
                card.motor_countdown = (cfg_shadow.motor_ticks == '0) ?
                                       TICK_WIDTH'(1) : cfg_shadow.motor_ticks;
              end
              card.motor_strobe = bit_set;
            end
            CRU_HOLD: card.hold_enable = bit_set;
            CRU_DRIVE1, CRU_DRIVE2, CRU_DRIVE3: begin
              drive_bit = 3'b001 << (cru_bit - CRU_DRIVE1);
              if (bit_set) begin
                if ((card.drive_mask & drive_bit) == 3'd0) begin
                  card.drive_mask = card.drive_mask | drive_bit;
                  r.drive_set = 2'(cru_bit - CRU_HEAD);
                end
              end else begin
                card.drive_mask = card.drive_mask & ~drive_bit;
              end
            end
            CRU_SIDE: card.side = bit_set;
            default: ;
          endcase
        end
      end
      OP_MEM_READ: begin
        if (in_window) begin
          if ((addr[12:0] & REG_DEC_MASK) == REG_RD_MATCH) begin
            r.ctl_access = CTL_READ;
            r.ctl_register = addr[2:1];
            r.data_out = ~cdata;
            r.data_valid = 1'b1;
          end else begin
            r.rom_select = 1'b1;
            r.rom_address = addr[12:0];
          end
        end
      end
      OP_MEM_WRITE: begin
        if (in_window && (addr[12:0] & REG_DEC_MASK) == REG_WR_MATCH) begin
          r.ctl_access = CTL_WRITE;
          r.ctl_register = addr[2:1];
          r.data_out = ~wdata;
        end
      end
      OP_IRQ_LINE: card.irq_drq_flags[0] = level;
      OP_DRQ_LINE: card.irq_drq_flags[1] = level;
      OP_TICK: begin
        if (card.motor_countdown != '0) begin
          card.motor_countdown = card.motor_countdown - TICK_WIDTH'(1);
          if (card.motor_countdown == '0) begin
            card.motor_run = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.halt_line = card.hold_enable && card.irq_drq_flags == 2'd0 && card.motor_run;
    r.intb_line = card.irq_drq_flags[0];
    r.drive_bits = card.drive_mask;
    r.side_select = card.side;
    r.motor_enable = card.motor_run;
    return r;
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [AW-1:0] addr,
                           input logic [7:0] wdata, input logic [7:0] cdata,
                           input logic level);
    fcg_result_t predicted;
    logic        motor_was_on;
    while (send_gaps_on && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.address <= addr;
    in_ch.data <= wdata;
    in_ch.controller_data <= cdata;
    in_ch.line_level <= level;
    do @(posedge clk_i); while (!in_ch.ready);
    motor_was_on = card.motor_run;
    predicted = card_step(op, addr, wdata, cdata, level);
    expected_results.push_back(predicted);
    items_sent++;
    if (predicted.ctl_access != CTL_NONE) ctl_hits++;
    if (predicted.rom_select) rom_hits++;
    if (motor_was_on && !predicted.motor_enable) motor_stops++;
  endtask

  // mostly well-formed card accesses with random content, some noise
  task automatic send_random();
    logic [2:0]    op;
    logic [AW-1:0] addr;
    logic [7:0]    wdata;
    int unsigned   pick;
    addr = AW'($urandom);
    wdata = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 28) begin
      op = OP_CRU_WRITE;
      if ($urandom_range(9) != 0) addr[15:8] = CRU_BASE_HI;
      // keep the card selected most of the time so the window stays reachable
      if (addr[3:1] == CRU_CARD_SEL ? $urandom_range(9) == 0 : $urandom_range(2) == 0) begin
        wdata = 8'd0;
      end
    end else if (pick < 38) begin
      op = OP_CRU_READ;
      if ($urandom_range(9) != 0) addr[15:8] = CRU_BASE_HI;
      if ($urandom_range(1) == 0) addr[2:0] = 3'd0;
    end else if (pick < 72) begin
      op = (pick < 58) ? OP_MEM_READ : OP_MEM_WRITE;
      if ($urandom_range(6) != 0) begin
        addr = (cfg_shadow.win_base & cfg_shadow.win_mask) |
               (addr & ~cfg_shadow.win_mask);
        if ($urandom_range(1) == 0) begin
          addr[12:0] = ((op == OP_MEM_READ) ? REG_RD_MATCH : REG_WR_MATCH) |
                       {10'd0, 2'($urandom), 1'b0};
        end
      end
    end else if (pick < 79) begin
      op = OP_IRQ_LINE;
    end else if (pick < 86) begin
      op = OP_DRQ_LINE;
    end else if (pick < 98) begin
      op = OP_TICK;
    end else begin
      op = OP_UNUSED;
    end
    send_item(op, addr, wdata, 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_card(input logic [SEL_WIDTH-1:0] mask,
                              input logic [SEL_WIDTH-1:0] value,
                              input logic [TICK_WIDTH-1:0] ticks);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIN_MASK;
    cfg_data <= mask;
    @(posedge clk_i);
    cfg_index <= CFG_WIN_BASE;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_index <= CFG_MOTOR_TICKS;
    cfg_data <= SEL_WIDTH'(ticks);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_shadow.win_mask = mask;
    cfg_shadow.win_base = value;
    cfg_shadow.motor_ticks = ticks;
    settings_used++;
  endtask

  task automatic report_field(input string name, input logic [12:0] want,
                              input logic [12:0] got);
    if (want !== got) begin
      fail_count++;
      if (mismatch_lines < MAX_MISMATCH_LINES) begin
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
      mismatch_lines++;
    end
  endtask

  // decode paths with reset register values
  task automatic test_bus_decode();
    send_item(OP_CRU_READ, cru_at(CRU_CARD_SEL), 8'h00, 8'h00, 1'b0);
    send_item(OP_CRU_READ, cru_at(CRU_MOTOR), 8'h00, 8'h00, 1'b0);
    send_item(OP_CRU_READ, '1, 8'hff, 8'hff, 1'b1);
    send_item(OP_MEM_READ, win_at(REG_RD_MATCH), 8'h00, 8'h5a, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_CARD_SEL), 8'h01, 8'h00, 1'b0);
    send_item(OP_MEM_READ, win_at(REG_RD_MATCH), 8'h00, 8'h00, 1'b0);
    send_item(OP_MEM_READ, win_at(REG_RD_MATCH | 13'h6), 8'h00, 8'hff, 1'b0);
    send_item(OP_MEM_READ, win_at(13'h0000), 8'h00, 8'h00, 1'b0);
    send_item(OP_MEM_READ, win_at(13'h1fff), 8'h00, 8'h00, 1'b0);
    send_item(OP_MEM_WRITE, win_at(REG_WR_MATCH), 8'h00, 8'h00, 1'b0);
    send_item(OP_MEM_WRITE, win_at(REG_WR_MATCH | 13'h6), 8'hff, 8'h00, 1'b0);
    send_item(OP_MEM_WRITE, win_at(13'h0010), 8'h3c, 8'h00, 1'b0);
    send_item(OP_MEM_READ, '0, 8'h00, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_HOLD), 8'h80, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_MOTOR), 8'h01, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_DRIVE1), 8'h10, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_DRIVE3), 8'h02, 8'h00, 1'b0);
    // already selected drive gives no new selection
    send_item(OP_CRU_WRITE, cru_at(CRU_DRIVE1), 8'h04, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_HEAD), 8'hff, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_SIDE), 8'h08, 8'h00, 1'b0);
    send_item(OP_CRU_READ, cru_at(CRU_CARD_SEL), 8'h00, 8'h00, 1'b0);
    send_item(OP_IRQ_LINE, '0, 8'h00, 8'h00, 1'b1);
    send_item(OP_DRQ_LINE, '0, 8'h00, 8'h00, 1'b1);
    send_item(OP_IRQ_LINE, '0, 8'h00, 8'h00, 1'b0);
    send_item(OP_DRQ_LINE, '0, 8'h00, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_DRIVE3), 8'h00, 8'h00, 1'b0);
    send_item(OP_UNUSED, '1, 8'hff, 8'hff, 1'b1);
    send_item(OP_TICK, '0, 8'h00, 8'h00, 1'b0);
  endtask

  // strobe edges, countdown expiry, zero and full tick counts
  task automatic test_motor_timeout();
    program_card(WIN_MASK_RST, WIN_BASE_RST, '0);
    send_item(OP_CRU_WRITE, cru_at(CRU_MOTOR), 8'h00, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_MOTOR), 8'h40, 8'h00, 1'b0);
    send_item(OP_TICK, '0, 8'h00, 8'h00, 1'b0);
    send_item(OP_TICK, '0, 8'h00, 8'h00, 1'b0);
    // strobe still high, so no restart
    send_item(OP_CRU_WRITE, cru_at(CRU_MOTOR), 8'h01, 8'h00, 1'b0);
    send_item(OP_CRU_READ, cru_at(CRU_CARD_SEL), 8'h00, 8'h00, 1'b0);
    program_card(WIN_MASK_RST, WIN_BASE_RST, 16'd3);
    send_item(OP_CRU_WRITE, cru_at(CRU_MOTOR), 8'h00, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_MOTOR), 8'h20, 8'h00, 1'b0);
    repeat (3) send_item(OP_TICK, '0, 8'h00, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_DRIVE2), 8'h01, 8'h00, 1'b0);
    program_card(WIN_MASK_RST, WIN_BASE_RST, '1);
    send_item(OP_CRU_WRITE, cru_at(CRU_MOTOR), 8'h00, 8'h00, 1'b0);
    send_item(OP_CRU_WRITE, cru_at(CRU_MOTOR), 8'hff, 8'h00, 1'b0);
    repeat (2) send_item(OP_TICK, '0, 8'h00, 8'h00, 1'b0);
  endtask

  // result side holds off while items keep coming, so the input side must stall
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    send_gaps_on = 1'b0;
    repeat (24) send_random();
    send_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    program_card(WIN_MASK_RST, WIN_BASE_RST, 16'd12);
    repeat (PHASE_ITEMS) send_random();
    program_card('0, '0, 16'd1);
    repeat (PHASE_ITEMS) send_random();
    // stretch without any idling on either side
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    program_card('1, '1, '1);
    repeat (PHASE_ITEMS) send_random();
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
    program_card(SEL_WIDTH'($urandom), SEL_WIDTH'($urandom), 16'($urandom_range(40, 2)));
    repeat (PHASE_ITEMS) send_random();
    program_card('1, win_at(REG_RD_MATCH), '0);
    repeat (PHASE_ITEMS) send_random();
    program_card(WIN_MASK_RST, WIN_BASE_RST, MOTOR_TICKS_RST);
    repeat (PHASE_ITEMS) send_random();
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= '0;
    in_ch.address <= '0;
    in_ch.data <= '0;
    in_ch.controller_data <= '0;
    in_ch.line_level <= 1'b0;
    card = '0;
    cfg_shadow = '{win_mask: WIN_MASK_RST, win_base: WIN_BASE_RST,
                   motor_ticks: MOTOR_TICKS_RST};
    settings_used = 1;
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bus_decode();
    test_motor_timeout();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      fail_count++;
      $display("%0t %0d results never arrived", $time, expected_results.size());
    end
    $display("covered %0d bus transactions over %0d register settings, %0d results checked",
             items_sent, settings_used, results_checked);
    $display("controller register accesses %0d, rom reads %0d, motor timeouts %0d",
             ctl_hits, rom_hits, motor_stops);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side ready, with random holds and the long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(recv_gaps_on && $urandom_range(99) < 24);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    fcg_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t result transaction with nothing pending", $time);
      end else begin
        want = expected_results.pop_front();
        report_field("data_valid", 13'(want.data_valid), 13'(out_ch.data_valid));
        report_field("data_out", 13'(want.data_out), 13'(out_ch.data_out));
        report_field("rom_select", 13'(want.rom_select), 13'(out_ch.rom_select));
        report_field("rom_address", want.rom_address, out_ch.rom_address);
        report_field("ctl_access", 13'(want.ctl_access), 13'(out_ch.ctl_access));
        report_field("ctl_register", 13'(want.ctl_register), 13'(out_ch.ctl_register));
        report_field("halt_line", 13'(want.halt_line), 13'(out_ch.halt_line));
        report_field("intb_line", 13'(want.intb_line), 13'(out_ch.intb_line));
        report_field("drive_bits", 13'(want.drive_bits), 13'(out_ch.drive_bits));
        report_field("side_select", 13'(want.side_select), 13'(out_ch.side_select));
        report_field("drive_set", 13'(want.drive_set), 13'(out_ch.drive_set));
        report_field("motor_enable", 13'(want.motor_enable), 13'(out_ch.motor_enable));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t no transaction for %0d cycles, stopping", $time, QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/fcg_pkg.sv
rtl/fcg_in_if.sv
rtl/fcg_out_if.sv
rtl/fcg_core.sv
rtl/floppy_card_glue_logic.sv
dv/tb_floppy_card_glue_logic.sv
